FILE: hw/rtl/bmf_pkg.sv
// Shared constants, types and a helper function for the 7x7 box mean filter.
package bmf_pkg;

  // Image geometry limits.
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int MIN_DIM    = 7;

  // Field and state widths.
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 10;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int COL_SUM_W = 11;
  localparam int WIN_SUM_W = 14;

  // Window geometry.
  localparam int WIN   = 7;
  localparam int LINES = WIN - 1;
  localparam int HALF  = WIN / 2;

  // Division by 49 as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every sum up to 49 * 255.
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MULT  = 21400;
  localparam int DIV_MUL_W = 15;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // Per-cycle control shared by every line buffer cell.
  typedef struct packed {
    logic              en;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              fwd;
  } bmf_cell_ctrl_t;

  // Clamp a programmed dimension to the supported range.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/bmf_line_cell.sv
// One line buffer cell: stores one image row and passes its old pixel to the next cell.
module bmf_line_cell (
  input  logic                                   clk,
  input  bmf_pkg::bmf_cell_ctrl_t                ctrl,
  input  logic [bmf_pkg::PIX_W-1:0]              wr_data,
  input  logic [bmf_pkg::COL_SUM_W-1:0]          sum_in,
  output logic [bmf_pkg::PIX_W-1:0]              line_out,
  output logic [bmf_pkg::COL_SUM_W-1:0]          sum_out
);

  logic [bmf_pkg::PIX_W-1:0] mem [bmf_pkg::MAX_WIDTH];
  logic [bmf_pkg::PIX_W-1:0] rd_q_r;
  logic                      fwd_r;
  logic [bmf_pkg::PIX_W-1:0] fwd_data_r;

  // Row memory: at most one write and one registered read per cycle, each only when enabled.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_data;
    end
    if (ctrl.en) begin
      rd_q_r     <= mem[ctrl.rd_addr];
      fwd_r      <= ctrl.fwd;
      fwd_data_r <= wr_data;
    end
  end

  // A read that collided with the write in the same cycle takes the written value.
  assign line_out = fwd_r ? fwd_data_r : rd_q_r;

  // Column sum accumulates along the chain.
  assign sum_out = sum_in + bmf_pkg::COL_SUM_W'(line_out);

endmodule

FILE: hw/rtl/bmf_col_window.sv
// Seven-deep column sum window with a running 7x7 window sum.
module bmf_col_window (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 upd,
  input  logic                                 clear,
  input  logic [bmf_pkg::COL_SUM_W-1:0]        col_sum,
  output logic [bmf_pkg::WIN_SUM_W-1:0]        window_sum
);

  logic [bmf_pkg::COL_SUM_W-1:0] cw_r   [bmf_pkg::WIN];
  logic [bmf_pkg::COL_SUM_W-1:0] cw_nxt [bmf_pkg::WIN];
  logic [bmf_pkg::WIN_SUM_W-1:0] ws_r;
  logic [bmf_pkg::WIN_SUM_W-1:0] ws_nxt;

  // Shift in the new column sum; a row start empties the window first.
  always_comb begin
    for (int k = 0; k < bmf_pkg::WIN - 1; k++) begin
      cw_nxt[k] = clear ? '0 : cw_r[k+1];
    end
    cw_nxt[bmf_pkg::WIN-1] = col_sum;
    if (clear) begin
      ws_nxt = bmf_pkg::WIN_SUM_W'(col_sum);
    end else begin
      ws_nxt = ws_r + bmf_pkg::WIN_SUM_W'(col_sum) - bmf_pkg::WIN_SUM_W'(cw_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bmf_pkg::WIN; k++) begin
        cw_r[k] <= '0;
      end
      ws_r <= '0;
    end else if (upd) begin
      cw_r <= cw_nxt;
      ws_r <= ws_nxt;
    end
  end

  assign window_sum = ws_r;

  // The running sum always equals the sum of the seven held column sums.
  assert property (@(posedge clk) disable iff (!rst_n)
    ws_r == bmf_pkg::WIN_SUM_W'(cw_r[0] + cw_r[1] + cw_r[2] + cw_r[3]
                                + cw_r[4] + cw_r[5] + cw_r[6]))
    else $error("window sum out of step with column window");

  // Seven column sums of at most seven pixels each bound the window sum.
  assert property (@(posedge clk) disable iff (!rst_n)
    ws_r <= bmf_pkg::WIN_SUM_W'(bmf_pkg::WIN * bmf_pkg::WIN * 255))
    else $error("window sum exceeds full-scale value");

endmodule

FILE: hw/rtl/box_mean_filter_7x7.sv
// Top level of the 7x7 box mean filter: position tracking, line cell chain and output.
// A result passes stage 1, stage 2, stage 3 and the output register before out_valid.
// Throughput: one pixel per cycle; the pipeline halts only while a held result is stalled.
// Each of the six line cells does at most one read and one write per cycle to its row memory.
// Reset clears position counters, column window, window sum and pipeline valids;
// row memories are not cleared and need no clearing pass.
module box_mean_filter_7x7 (
  input  logic                            clk,
  input  logic                            rst_n,
  // Pixel input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bmf_pkg::PIX_W-1:0]       in_pixel,
  input  logic                            in_frame_start,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_mean_value,
  output logic [8:0]                      out_center_row,
  output logic [8:0]                      out_center_col,
  output logic                            out_frame_done,
  // Configuration port
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [bmf_pkg::DIM_W-1:0]       cfg_data
);

  localparam int ADDR_W = bmf_pkg::ADDR_W;
  localparam int ROW_W  = bmf_pkg::ROW_W;
  localparam int DIM_W  = bmf_pkg::DIM_W;
  localparam int CS_W   = bmf_pkg::COL_SUM_W;
  localparam int WS_W   = bmf_pkg::WIN_SUM_W;
  localparam int PROD_W = WS_W + bmf_pkg::DIV_MUL_W;

  // Configuration registers.
  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_W'(bmf_pkg::MAX_WIDTH);
      image_height_r <= DIM_W'(bmf_pkg::MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bmf_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        bmf_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = bmf_pkg::clamp_dim(image_width_r, DIM_W'(bmf_pkg::MAX_WIDTH));
  assign h_eff = bmf_pkg::clamp_dim(image_height_r, DIM_W'(bmf_pkg::MAX_HEIGHT));

  // Pipeline advance: everything moves unless a held result is stalled.
  logic out_valid_r;
  logic en;
  logic in_acc;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign in_acc   = in_valid && en;

  // Position of the incoming pixel.
  logic [ROW_W-1:0]  row_count_r;
  logic [ADDR_W-1:0] col_count_r;
  logic [ROW_W-1:0]  r0;
  logic [ADDR_W-1:0] c0;
  logic [DIM_W-1:0]  c_inc;
  logic [DIM_W-1:0]  r_inc;

  assign r0    = in_frame_start ? '0 : row_count_r;
  assign c0    = in_frame_start ? '0 : col_count_r;
  assign c_inc = DIM_W'(c0) + DIM_W'(1);
  assign r_inc = DIM_W'(r0) + DIM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (in_acc) begin
      if (c_inc >= w_eff) begin
        col_count_r <= '0;
        row_count_r <= (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_count_r <= c_inc[ADDR_W-1:0];
        row_count_r <= r0;
      end
    end
  end

  // Stage 1: row memories are read; the item's side information waits here.
  logic                     valid1_r;
  logic [bmf_pkg::PIX_W-1:0] px1_r;
  logic [ADDR_W-1:0]        c1_r;
  logic                     full1_r;
  logic                     emit1_r;
  logic                     done1_r;
  logic [8:0]               crow1_r;
  logic [8:0]               ccol1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r   <= in_pixel;
      c1_r    <= c0;
      full1_r <= r0 >= ROW_W'(bmf_pkg::LINES);
      emit1_r <= (r0 >= ROW_W'(bmf_pkg::LINES)) && (c0 >= ADDR_W'(bmf_pkg::LINES));
      done1_r <= (r_inc >= h_eff) && (c_inc >= w_eff);
      crow1_r <= 9'(r0 - ROW_W'(bmf_pkg::HALF));
      ccol1_r <= 9'(c0 - ADDR_W'(bmf_pkg::HALF));
    end
  end

  // Chain of line cells: each stores its input and hands the previous row on.
  bmf_pkg::bmf_cell_ctrl_t  cell_ctrl;
  logic [bmf_pkg::PIX_W-1:0] line_data [bmf_pkg::LINES];
  logic [bmf_pkg::PIX_W-1:0] cell_wr   [bmf_pkg::LINES];
  logic [CS_W-1:0]          sum_chain [bmf_pkg::LINES+1];

  always_comb begin
    cell_ctrl.en      = en;
    cell_ctrl.wr_en   = en && valid1_r;
    cell_ctrl.rd_addr = c0;
    cell_ctrl.wr_addr = c1_r;
    cell_ctrl.fwd     = valid1_r && (c1_r == c0);
  end

  assign sum_chain[0] = '0;

  for (genvar k = 0; k < bmf_pkg::LINES; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_wr[k] = px1_r;
    end else begin : g_next
      assign cell_wr[k] = line_data[k-1];
    end

    bmf_line_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .wr_data  (cell_wr[k]),
      .sum_in   (sum_chain[k]),
      .line_out (line_data[k]),
      .sum_out  (sum_chain[k+1])
    );
  end

  // Column sum: the new pixel plus the six rows above once they exist.
  logic [CS_W-1:0] col_sum1;

  assign col_sum1 = CS_W'(px1_r) + (full1_r ? sum_chain[bmf_pkg::LINES] : '0);

  // Stage 2: registered column sum.
  logic            valid2_r;
  logic [CS_W-1:0] colsum2_r;
  logic            clear2_r;
  logic            emit2_r;
  logic            done2_r;
  logic [8:0]      crow2_r;
  logic [8:0]      ccol2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else if (en) begin
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      colsum2_r <= col_sum1;
      clear2_r  <= c1_r == '0;
      emit2_r   <= emit1_r;
      done2_r   <= done1_r;
      crow2_r   <= crow1_r;
      ccol2_r   <= ccol1_r;
    end
  end

  // Stage 3: window sum update.
  logic [WS_W-1:0] window_sum;
  logic            valid3_r;
  logic            emit3_r;
  logic            done3_r;
  logic [8:0]      crow3_r;
  logic [8:0]      ccol3_r;

  bmf_col_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (en && valid2_r),
    .clear      (clear2_r),
    .col_sum    (colsum2_r),
    .window_sum (window_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
    end else if (en) begin
      valid3_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emit3_r <= emit2_r;
      done3_r <= done2_r;
      crow3_r <= crow2_r;
      ccol3_r <= ccol2_r;
    end
  end

  // Divide by 49 through the reciprocal multiply.
  logic [PROD_W-1:0] mean_prod;

  assign mean_prod = PROD_W'(window_sum) * PROD_W'(bmf_pkg::DIV_MULT);

  // Output register.
  logic [7:0] mean_r;
  logic [8:0] crow_r;
  logic [8:0] ccol_r;
  logic       done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid3_r && emit3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_r <= mean_prod[bmf_pkg::DIV_SHIFT +: 8];
      crow_r <= crow3_r;
      ccol_r <= ccol3_r;
      done_r <= done3_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_center_row = crow_r;
  assign out_center_col = ccol_r;
  assign out_frame_done = done_r;

  // Input is held off only while a result is waiting on a stalled receiver.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // Every emitted centre lies inside the three-pixel border.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (crow_r >= 9'(bmf_pkg::HALF)) && (ccol_r >= 9'(bmf_pkg::HALF)))
    else $error("result emitted for a border pixel");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the 7x7 box mean filter, with its own window-mean predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmf_pkg::*;

  localparam int unsigned WINDOW_AREA  = WIN * WIN;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;

  // One window mean as it leaves the block.
  typedef struct packed {
    logic [7:0] mean;
    logic [8:0] row;
    logic [8:0] col;
    logic       done;
  } mean_result_t;

  // A run of identical pixels in the directed part, optionally after new dimensions.
  typedef struct {
    bit                 wr_dims;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    int unsigned        count;
    logic [PIX_W-1:0]   pix;
    logic               fs;
    bit                 typed;
    mean_result_t       want;
  } burst_t;

  // One random phase: image dimensions, length and handshake pressure.
  typedef struct {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int unsigned      count;
    int unsigned      send_pct;
    int unsigned      stall_pct;
    bit               hold;
    bit               restart;
    bit               noise;
  } phase_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_mean_value;
  logic [8:0]         out_center_row;
  logic [8:0]         out_center_col;
  logic               out_frame_done;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = CFG_IMAGE_WIDTH;
  logic [DIM_W-1:0]   cfg_data = '0;

  // Predictor state: six stored rows, the column window, the running sum and the position.
  logic [PIX_W-1:0]     line_rows [LINES][MAX_WIDTH];
  logic [COL_SUM_W-1:0] col_sums [WIN];
  logic [WIN_SUM_W-1:0] win_sum;
  int unsigned          row_pos;
  int unsigned          col_pos;
  logic [DIM_W-1:0]     dim_width = 10'd512;
  logic [DIM_W-1:0]     dim_height = 10'd512;

  mean_result_t pending_means [$];
  int           fail_count = 0;
  int unsigned  send_pct = 0;
  int unsigned  stall_pct = 0;
  logic         receiver_hold = 1'b0;
  event         hold_go;

  burst_t bursts [9];
  phase_t plan [10];

  box_mean_filter_7x7 DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mean_value (out_mean_value),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_frame_done (out_frame_done),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the predicted filter by one pixel; returns whether a window mean is produced.
  function automatic bit predict_window(input logic [PIX_W-1:0] pix, input logic fs,
                                        output mean_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned csum;
    int unsigned k;
    bit hit;
    w = (dim_width < MIN_DIM) ? MIN_DIM : ((dim_width > MAX_WIDTH) ? MAX_WIDTH : dim_width);
    h = (dim_height < MIN_DIM) ? MIN_DIM
        : ((dim_height > MAX_HEIGHT) ? MAX_HEIGHT : dim_height);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;

    // Column sum over the six stored rows plus the new pixel.
    csum = pix;
    if (c < MAX_WIDTH) begin
      if (r >= LINES) begin
        for (k = 0; k < LINES; k++) csum += line_rows[k][c];
      end
      line_rows[r % LINES][c] = pix;
    end

    // The horizontal window restarts at the left edge of every row.
    if (c == 0) begin
      for (k = 0; k < WIN; k++) col_sums[k] = '0;
      win_sum = '0;
    end
    win_sum = WIN_SUM_W'(win_sum + csum - col_sums[0]);
    for (k = 0; k + 1 < WIN; k++) col_sums[k] = col_sums[k + 1];
    col_sums[WIN - 1] = COL_SUM_W'(csum);

    hit = (r >= LINES) && (c >= LINES);
    res = '0;
    if (hit) begin
      res.mean = 8'(win_sum / WINDOW_AREA);
      res.row  = 9'(r - HALF);
      res.col  = 9'(c - HALF);
      res.done = (r + 1 >= h) && (c + 1 >= w);
    end

    // Step the raster position, wrapping at the end of the row and of the frame.
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: check every accepted result request, then pick the next stall.
  always @(posedge clk) begin : result_monitor
    mean_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        $error("result at row %0d col %0d with nothing expected", out_center_row,
               out_center_col);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        check_field("mean_value", want.mean, out_mean_value);
        check_field("center_row", want.row, out_center_row);
        check_field("center_col", want.col, out_center_col);
        check_field("frame_done", want.done, out_frame_done);
      end
    end
    out_stall <= receiver_hold || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off so the pipeline fills and pushes back on the input.
  initial begin : receiver_hold_off
    forever begin
      @(hold_go);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  // Predict one pixel, then offer it as a request until it is accepted.
  task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic fs, input bit typed,
                             input mean_result_t want);
    mean_result_t got;
    bit hit;
    hit = predict_window(pix, fs, got);
    if (typed) begin
      pending_means.push_back(want);
    end else if (hit) begin
      pending_means.push_back(got);
    end
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait until every expected mean has arrived and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program both image dimensions on back-to-back cycles.
  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    dim_width  = w;
    dim_height = h;
  endtask

  initial begin : stimulus
    mean_result_t no_mean;
    logic [PIX_W-1:0] pix;
    logic fs;
    int unsigned n;
    int unsigned k;
    no_mean = '0;
    for (k = 0; k < LINES * MAX_WIDTH; k++) line_rows[k / MAX_WIDTH][k % MAX_WIDTH] = '0;
    for (k = 0; k < WIN; k++) col_sums[k] = '0;
    win_sum = '0;
    row_pos = 0;
    col_pos = 0;

    // Directed runs. The first uses the reset dimensions and yields nothing; the
    // rest cover full-scale frames, wrap without frame start, restart mid-frame,
    // and a frame end reached on a column past the first window.
    bursts[0] = '{1'b0, 10'd0, 10'd0, 10, 8'hFF, 1'b1, 1'b0, '0};
    bursts[1] = '{1'b1, 10'd7, 10'd7, 49, 8'hFF, 1'b1, 1'b1,
                  mean_result_t'{8'd255, 9'd3, 9'd3, 1'b1}};
    bursts[2] = '{1'b0, 10'd0, 10'd0, 49, 8'h00, 1'b0, 1'b1,
                  mean_result_t'{8'd0, 9'd3, 9'd3, 1'b1}};
    bursts[3] = '{1'b0, 10'd0, 10'd0, 20, 8'd128, 1'b1, 1'b0, '0};
    bursts[4] = '{1'b0, 10'd0, 10'd0, 49, 8'd200, 1'b1, 1'b1,
                  mean_result_t'{8'd200, 9'd3, 9'd3, 1'b1}};
    bursts[5] = '{1'b0, 10'd0, 10'd0, 48, 8'd1, 1'b0, 1'b0, '0};
    bursts[6] = '{1'b0, 10'd0, 10'd0, 1, 8'd50, 1'b0, 1'b1,
                  mean_result_t'{8'd2, 9'd3, 9'd3, 1'b1}};
    bursts[7] = '{1'b1, 10'd8, 10'd7, 55, 8'd9, 1'b1, 1'b1,
                  mean_result_t'{8'd9, 9'd3, 9'd3, 1'b0}};
    bursts[8] = '{1'b0, 10'd0, 10'd0, 1, 8'd58, 1'b0, 1'b1,
                  mean_result_t'{8'd10, 9'd3, 9'd4, 1'b1}};

    // Random phases. Out-of-range dimensions are clamped by the block. The phase
    // ending mid-frame is followed by a narrower width without a frame start.
    plan[0] = '{10'd0, 10'd3, 80, 0, 0, 1'b0, 1'b1, 1'b1};
    plan[1] = '{10'd9, 10'd8, 100, 70, 0, 1'b0, 1'b1, 1'b1};
    plan[2] = '{10'd12, 10'd7, 100, 0, 70, 1'b0, 1'b1, 1'b1};
    plan[3] = '{10'd16, 10'd10, 120, 31, 31, 1'b0, 1'b1, 1'b1};
    plan[4] = '{10'd10, 10'd9, 120, 0, 0, 1'b1, 1'b1, 1'b1};
    plan[5] = '{10'd12, 10'd9, 93, 0, 31, 1'b0, 1'b1, 1'b0};
    plan[6] = '{10'd7, 10'd9, 80, 31, 70, 1'b0, 1'b0, 1'b1};
    plan[7] = '{10'd6, 10'd512, 80, 70, 31, 1'b0, 1'b1, 1'b1};
    plan[8] = '{10'd1023, 10'd0, 100, 0, 31, 1'b0, 1'b1, 1'b1};
    plan[9] = '{10'd20, 10'd12, 150, 31, 31, 1'b0, 1'b1, 1'b1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling on either side.
    foreach (bursts[i]) begin
      if (bursts[i].wr_dims) begin
        settle();
        write_dims(bursts[i].w, bursts[i].h);
      end
      for (n = 0; n < bursts[i].count; n++) begin
        offer_pixel(bursts[i].pix, (n == 0) ? bursts[i].fs : 1'b0,
                    bursts[i].typed && (n + 1 == bursts[i].count), bursts[i].want);
      end
    end
    settle();

    // Random part: mostly well-formed frames, with an occasional stray frame start.
    foreach (plan[i]) begin
      write_dims(plan[i].w, plan[i].h);
      send_pct = plan[i].send_pct;
      stall_pct <= plan[i].stall_pct;
      if (plan[i].hold) -> hold_go;
      for (n = 0; n < plan[i].count; n++) begin
        case ($urandom_range(7))
          0: pix = 8'h00;
          1: pix = 8'hFF;
          default: pix = 8'($urandom_range(255));
        endcase
        if (n == 0 && plan[i].restart) begin
          fs = 1'b1;
        end else if (row_pos == 0 && col_pos == 0) begin
          fs = ($urandom_range(3) != 0);
        end else begin
          fs = plan[i].noise && ($urandom_range(249) == 0);
        end
        offer_pixel(pix, fs, 1'b0, no_mean);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: box_mean_filter_7x7.f
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_line_cell.sv
hw/rtl/bmf_col_window.sv
hw/rtl/box_mean_filter_7x7.sv
tb/sv/tb_top.sv
